// File: rtl/qvr_pkg.sv
// Shared constants for the quaternion vector rotation unit.
// Register indexes, default widths and the product/term tables used by the front end.
package qvr_pkg;

  localparam int unsigned QVR_COORD_WIDTH  = 32;
  localparam int unsigned QVR_QUAT_WIDTH   = 16;
  localparam int unsigned QVR_ROT_W_RESET  = 4096;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ROT_W  = 3'd0,
    REG_ROT_X  = 3'd1,
    REG_ROT_Y  = 3'd2,
    REG_ROT_Z  = 3'd3,
    REG_UNROT  = 3'd4
  } qvr_reg_e;

  localparam int QVR_NPROD = 10;
  localparam int QVR_NTERM = 8;

  // quaternion products: ww xx yy zz xy xz yz wx wy wz
  localparam int PROD_A [0:9] = '{0, 1, 2, 3, 1, 1, 2, 0, 0, 0};
  localparam int PROD_B [0:9] = '{0, 1, 2, 3, 2, 3, 3, 1, 2, 3};

  // per output coordinate: product used, point column, coefficient
  localparam int TERM_PROD [0:2][0:7] = '{
    '{0, 1, 2, 3, 4, 9, 5, 8},
    '{4, 9, 0, 1, 2, 3, 6, 7},
    '{5, 8, 6, 7, 0, 1, 2, 3}
  };
  localparam int TERM_COL [0:2][0:7] = '{
    '{0, 0, 0, 0, 1, 1, 2, 2},
    '{0, 0, 1, 1, 1, 1, 2, 2},
    '{0, 0, 1, 1, 2, 2, 2, 2}
  };
  localparam int TERM_COEF [0:2][0:7] = '{
    '{1, 1, -1, -1, 2, -2, 2, 2},
    '{2, 2, 1, -1, 1, -1, 2, -2},
    '{2, -2, 2, 2, 1, -1, -1, 1}
  };

endpackage

// File: rtl/qvr_front.sv
// Front end: quaternion products, point terms, numerator sums and divider operands.
// Four register stages; uses qvr_pkg tables.
module qvr_front import qvr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = QVR_COORD_WIDTH,
  parameter int unsigned QUAT_WIDTH  = QVR_QUAT_WIDTH,
  localparam int unsigned PW  = 2 * QUAT_WIDTH + 1,
  localparam int unsigned TW  = PW + COORD_WIDTH,
  localparam int unsigned NW  = TW + 4,
  localparam int unsigned RW  = NW + 1,
  localparam int unsigned DW  = 2 * QUAT_WIDTH + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] pt_i [3],
  input  logic signed [QUAT_WIDTH:0]    quat_i [4],
  output logic                          valid_o,
  output logic        [RW-1:0]          num_o [3],
  output logic                          neg_o [3],
  output logic        [DW-1:0]          den_o,
  output logic                          zero_o
);

  logic                          s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic signed [PW-1:0]          s1_prod_d [QVR_NPROD];
  logic signed [PW-1:0]          s1_prod_q [QVR_NPROD];
  logic signed [COORD_WIDTH-1:0] s1_pt_q [3];
  logic signed [TW-1:0]          s2_term_d [3][QVR_NTERM];
  logic signed [TW-1:0]          s2_term_q [3][QVR_NTERM];
  logic        [PW-1:0]          s2_nrm_d, s2_nrm_q, s3_nrm_q;
  logic signed [NW-1:0]          s3_acc_d [3];
  logic signed [NW-1:0]          s3_acc_q [3];
  logic        [RW-1:0]          s4_num_d [3];
  logic        [RW-1:0]          s4_num_q [3];
  logic                          s4_neg_q [3];
  logic        [DW-1:0]          s4_den_q;
  logic                          s4_zero_q;

  // stage 1: ten products of quaternion parts
  always_comb begin
    logic signed [2*QUAT_WIDTH+1:0] full;
    for (int k = 0; k < QVR_NPROD; k++) begin
      full = quat_i[PROD_A[k]] * quat_i[PROD_B[k]];
      s1_prod_d[k] = full[PW-1:0];
    end
  end

  // stage 2: point terms and norm
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < QVR_NTERM; k++) begin
        s2_term_d[i][k] = s1_prod_q[TERM_PROD[i][k]] * s1_pt_q[TERM_COL[i][k]];
      end
    end
    s2_nrm_d = s1_prod_q[0] + s1_prod_q[1] + s1_prod_q[2] + s1_prod_q[3];
  end

  // stage 3: signed, weighted sum of eight terms per coordinate
  always_comb begin
    logic signed [NW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      s3_acc_d[i] = '0;
      for (int k = 0; k < QVR_NTERM; k++) begin
        t = {{4{s2_term_q[i][k][TW-1]}}, s2_term_q[i][k]};
        if (TERM_COEF[i][k] < 0) t = -t;
        if (TERM_COEF[i][k] == 2 || TERM_COEF[i][k] == -2) t = t <<< 1;
        s3_acc_d[i] = s3_acc_d[i] + t;
      end
    end
  end

  // stage 4: rounded dividend 2|n| + norm
  always_comb begin
    logic [NW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = s3_acc_q[i][NW-1] ? NW'(-s3_acc_q[i]) : NW'(s3_acc_q[i]);
      s4_num_d[i] = {mag, 1'b0} + RW'(s3_nrm_q);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s1_prod_q <= s1_prod_d;
    s1_pt_q   <= pt_i;
    s2_term_q <= s2_term_d;
    s2_nrm_q  <= s2_nrm_d;
    s3_acc_q  <= s3_acc_d;
    s3_nrm_q  <= s2_nrm_q;
    s4_num_q  <= s4_num_d;
    for (int i = 0; i < 3; i++) s4_neg_q[i] <= s3_acc_q[i][NW-1];
    s4_den_q  <= {s3_nrm_q, 1'b0};
    s4_zero_q <= (s3_nrm_q == '0);
  end

  assign valid_o = s4_valid_q;
  assign num_o   = s4_num_q;
  assign neg_o   = s4_neg_q;
  assign den_o   = s4_den_q;
  assign zero_o  = s4_zero_q;

endmodule

// File: rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor.
// Uses qvr_pkg for default widths.
module qvr_div import qvr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = QVR_COORD_WIDTH,
  parameter int unsigned QUAT_WIDTH  = QVR_QUAT_WIDTH,
  localparam int unsigned RW = 2 * QUAT_WIDTH + COORD_WIDTH + 6,
  localparam int unsigned DW = 2 * QUAT_WIDTH + 2,
  localparam int unsigned QB = COORD_WIDTH + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [RW-1:0] num_i [3],
  input  logic          neg_i [3],
  input  logic [DW-1:0] den_i,
  input  logic          zero_i,
  output logic          valid_o,
  output logic [QB-1:0] quo_o [3],
  output logic          neg_o [3],
  output logic          zero_o
);

  // index 0 is the input, index s+1 the register of stage s
  logic          valid_w [QB+1];
  logic [RW-1:0] rem_w   [QB+1][3];
  logic [QB-1:0] quo_w   [QB+1][3];
  logic          neg_w   [QB+1][3];
  logic [DW-1:0] den_w   [QB+1];
  logic          zero_w  [QB+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = num_i;
  assign neg_w[0]   = neg_i;
  assign den_w[0]   = den_i;
  assign zero_w[0]  = zero_i;
  for (genvar l = 0; l < 3; l++) begin : g_q0
    assign quo_w[0][l] = '0;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW-1:0] rem_d [3];
    logic [QB-1:0] quo_d [3];

    // compare and subtract the divisor aligned to this bit
    always_comb begin
      logic [RW-1:0] sh;
      sh = RW'(den_w[s]) << (QB - 1 - s);
      for (int l = 0; l < 3; l++) begin
        if (rem_w[s][l] >= sh) begin
          rem_d[l] = rem_w[s][l] - sh;
          quo_d[l] = {quo_w[s][l][QB-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_w[s][l];
          quo_d[l] = {quo_w[s][l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_w[s+1] <= 1'b0;
      end else begin
        valid_w[s+1] <= valid_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_w[s+1]  <= rem_d;
      quo_w[s+1]  <= quo_d;
      neg_w[s+1]  <= neg_w[s];
      den_w[s+1]  <= den_w[s];
      zero_w[s+1] <= zero_w[s];
    end
  end

  assign valid_o = valid_w[QB];
  assign quo_o   = quo_w[QB];
  assign neg_o   = neg_w[QB];
  assign zero_o  = zero_w[QB];

endmodule

// File: rtl/quaternion_vector_rotate_unit.sv
// Pipeline from start to done:
// four front-end stages, one divider stage per quotient bit, one output stage.
// Throughput: one point per cycle; busy_o is never raised and results cannot be stalled.
// Reset: asynchronous, active low; clears valid bits and loads the identity quaternion.
// Uses qvr_pkg, qvr_front and qvr_div.
module quaternion_vector_rotate_unit import qvr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = QVR_COORD_WIDTH,
  parameter int unsigned QUAT_WIDTH  = QVR_QUAT_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [QUAT_WIDTH-1:0]         cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] pt_x_i,
  input  logic signed [COORD_WIDTH-1:0] pt_y_i,
  input  logic signed [COORD_WIDTH-1:0] pt_z_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          saturated_o,
  output logic                          zero_norm_o
);

  localparam int unsigned RW = 2 * QUAT_WIDTH + COORD_WIDTH + 6;
  localparam int unsigned DW = 2 * QUAT_WIDTH + 2;
  localparam int unsigned QB = COORD_WIDTH + 1;

  logic [QUAT_WIDTH-1:0] rot_q [4];
  logic                  unrot_q;
  logic signed [QUAT_WIDTH:0]    quat [4];
  logic signed [COORD_WIDTH-1:0] pt [3];

  logic          f_valid, d_valid, f_zero, d_zero;
  logic [RW-1:0] f_num [3];
  logic          f_neg [3], d_neg [3];
  logic [DW-1:0] f_den;
  logic [QB-1:0] d_quo [3];

  logic                   out_valid_q;
  logic [COORD_WIDTH-1:0] out_d [3];
  logic [COORD_WIDTH-1:0] out_q [3];
  logic                   sat_d, sat_q, zero_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= QUAT_WIDTH'(QVR_ROT_W_RESET);
      rot_q[1] <= '0;
      rot_q[2] <= '0;
      rot_q[3] <= '0;
      unrot_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (qvr_reg_e'(cfg_idx_i))
        REG_ROT_W: rot_q[0] <= cfg_wdata_i;
        REG_ROT_X: rot_q[1] <= cfg_wdata_i;
        REG_ROT_Y: rot_q[2] <= cfg_wdata_i;
        REG_ROT_Z: rot_q[3] <= cfg_wdata_i;
        REG_UNROT: unrot_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // quaternion, conjugated in unrotate mode
  always_comb begin
    logic signed [QUAT_WIDTH:0] e;
    for (int k = 0; k < 4; k++) begin
      e = {rot_q[k][QUAT_WIDTH-1], rot_q[k]};
      quat[k] = (k > 0 && unrot_q) ? -e : e;
    end
  end

  assign pt[0]  = pt_x_i;
  assign pt[1]  = pt_y_i;
  assign pt[2]  = pt_z_i;
  assign busy_o = 1'b0;

  qvr_front #(.COORD_WIDTH(COORD_WIDTH), .QUAT_WIDTH(QUAT_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .pt_i    (pt),
    .quat_i  (quat),
    .valid_o (f_valid),
    .num_o   (f_num),
    .neg_o   (f_neg),
    .den_o   (f_den),
    .zero_o  (f_zero)
  );

  qvr_div #(.COORD_WIDTH(COORD_WIDTH), .QUAT_WIDTH(QUAT_WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .num_i   (f_num),
    .neg_i   (f_neg),
    .den_i   (f_den),
    .zero_i  (f_zero),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .neg_o   (d_neg),
    .zero_o  (d_zero)
  );

  // sign restore, saturation and zero-norm clearing
  always_comb begin
    logic [QB-1:0] half;
    half  = QB'(1) << (COORD_WIDTH - 1);
    sat_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (d_zero) begin
        out_d[l] = '0;
      end else if (d_neg[l]) begin
        if (d_quo[l] > half) begin
          sat_d    = 1'b1;
          out_d[l] = half[COORD_WIDTH-1:0];
        end else begin
          out_d[l] = COORD_WIDTH'(-d_quo[l]);
        end
      end else begin
        if (d_quo[l] > half - QB'(1)) begin
          sat_d    = 1'b1;
          out_d[l] = COORD_WIDTH'(half - QB'(1));
        end else begin
          out_d[l] = d_quo[l][COORD_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    sat_q  <= sat_d;
    zero_q <= d_zero;
  end

  assign done_o      = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign saturated_o = sat_q;
  assign zero_norm_o = zero_q;

endmodule

// File: rtl/qvr_checker.sv
// Port-level checks for quaternion_vector_rotate_unit, attached by bind.
// Uses qvr_pkg for default widths.
module qvr_checker import qvr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = QVR_COORD_WIDTH,
  parameter int unsigned QUAT_WIDTH  = QVR_QUAT_WIDTH
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic signed [COORD_WIDTH-1:0] out_x_o,
  input logic signed [COORD_WIDTH-1:0] out_y_o,
  input logic signed [COORD_WIDTH-1:0] out_z_o,
  input logic                          saturated_o,
  input logic                          zero_norm_o
);

  localparam int unsigned LAT = COORD_WIDTH + 6;
  localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // every result traces back to an earlier accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without matching request");

  // zero norm gives zero coordinates and no saturation
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_norm_o |->
      out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && !saturated_o)
    else $error("zero norm result not cleared");

  // a saturated result has a coordinate at a bound
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      out_x_o == MAXV || out_x_o == MINV || out_y_o == MAXV ||
      out_y_o == MINV || out_z_o == MAXV || out_z_o == MINV)
    else $error("saturation flag without clipped coordinate");

  // requests are never refused
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("request refused");

endmodule

bind quaternion_vector_rotate_unit qvr_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .QUAT_WIDTH (QUAT_WIDTH)
) u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .saturated_o (saturated_o),
  .zero_norm_o (zero_norm_o)
);
